// File: rtl/marvs_pkg.sv
// Package for the mesh adaptive route and VC select block.
// Holds direction and class codes, the route result type and defaults.
// No dependencies.
package marvs_pkg;

  localparam int MESH_RADIX_DEF = 8;

  localparam int NODE_W = 6;

  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_XN = 2'd1,
    DIR_YP = 2'd2,
    DIR_YN = 2'd3
  } dir_t;

  localparam logic [3:0] CLASS_1 = 4'd1;
  localparam logic [3:0] CLASS_2 = 4'd2;
  localparam logic [3:0] CLASS_3 = 4'd3;
  localparam logic [3:0] CLASS_4 = 4'd4;
  localparam logic [3:0] CLASS_5 = 4'd5;
  localparam logic [3:0] CLASS_6 = 4'd6;
  localparam logic [3:0] CLASS_7 = 4'd7;
  localparam logic [3:0] CLASS_8 = 4'd8;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] next_node;
    dir_t              dir;
    logic              vc;
  } route_res_t;

endpackage

// File: rtl/marvs_route.sv
// Route computation for one mesh hop: neighbor checks, per-class preference
// and fallback gates, VC choice. Purely combinational.
// Depends on marvs_pkg.
module marvs_route import marvs_pkg::*; #(
  parameter int MESH_RADIX = MESH_RADIX_DEF
) (
  input  logic [NODE_W-1:0] cur_node,
  input  logic [NODE_W-1:0] dst_node,
  input  logic [NODE_W-1:0] prev_node,
  input  logic [3:0]        msg_class,
  input  logic              prev_vc,
  input  logic              coin,
  input  logic [3:0]        vc0_busy,
  input  logic [3:0]        vc1_busy,
  input  logic [3:0]        bw_busy,
  output route_res_t        res
);

  localparam int NODES = MESH_RADIX * MESH_RADIX;

  logic [NODE_W-1:0] cx, cy, dx, dy, py;
  logic              xo, yo, came_down, on_mesh;
  logic [3:0]        ok, b0, b1, bb;
  logic [NODE_W-1:0] nid [4];

  logic en1, en2, g1, g2, vc1s, vc2s, hit1, hit2;
  dir_t d1, d2;
  logic low_vc, high_vc;

  always_comb begin
    cx = NODE_W'(cur_node % MESH_RADIX);
    cy = NODE_W'(cur_node / MESH_RADIX);
    dx = NODE_W'(dst_node % MESH_RADIX);
    dy = NODE_W'(dst_node / MESH_RADIX);
    py = NODE_W'(prev_node / MESH_RADIX);
    xo = dx != cx;
    yo = dy != cy;
    came_down = py > cy;
    on_mesh = {7'd0, cur_node} < 13'(NODES);

    ok[DIR_XP] = on_mesh && ({1'b0, cx} < 7'(MESH_RADIX - 1));
    ok[DIR_XN] = on_mesh && (cx != '0);
    ok[DIR_YP] = on_mesh && ({1'b0, cy} < 7'(MESH_RADIX - 1));
    ok[DIR_YN] = on_mesh && (cy != '0);

    b0 = vc0_busy & ok;
    b1 = vc1_busy & ok;
    bb = bw_busy & ok;

    nid[DIR_XP] = cur_node + NODE_W'(1);
    nid[DIR_XN] = cur_node - NODE_W'(1);
    nid[DIR_YP] = cur_node + NODE_W'(MESH_RADIX);
    nid[DIR_YN] = cur_node - NODE_W'(MESH_RADIX);
  end

  always_comb begin
    low_vc  = !(came_down || !prev_vc);
    high_vc = came_down || prev_vc;
    en1 = 1'b0; d1 = DIR_XP; vc1s = 1'b0; g1 = 1'b1;
    en2 = 1'b0; d2 = DIR_XP; vc2s = 1'b0; g2 = 1'b1;
    unique case (msg_class)
      CLASS_1: begin
        if (!coin) begin
          en1 = xo; d1 = DIR_XP; vc1s = 1'b1;
          en2 = yo; d2 = DIR_YP; vc2s = 1'b1;
        end else begin
          en1 = yo; d1 = DIR_YP; vc1s = 1'b1; g1 = !bb[DIR_YP] || b1[DIR_XP];
          en2 = xo; d2 = DIR_XP; vc2s = 1'b1; g2 = !bb[DIR_XP];
        end
      end
      CLASS_2: begin
        if (!coin) begin
          en1 = xo; d1 = DIR_XP; vc1s = low_vc; g1 = !bb[DIR_XP] || b1[DIR_YN];
          en2 = yo; d2 = DIR_YN; vc2s = 1'b1;
        end else begin
          en1 = yo; d1 = DIR_YN; vc1s = 1'b1;
          g1 = !bb[DIR_YN] || (b1[DIR_XP] && b0[DIR_XP]);
          en2 = xo; d2 = DIR_XP; vc2s = low_vc;
        end
      end
      CLASS_3: begin
        en1 = yo;        d1 = DIR_YP; vc1s = 1'b1;
        en2 = xo && !yo; d2 = DIR_XN; vc2s = 1'b1;
      end
      CLASS_4: begin
        if (!coin) begin
          en1 = xo; d1 = DIR_XN; vc1s = 1'b1; g1 = !bb[DIR_XN] || b1[DIR_YN];
          en2 = yo; d2 = DIR_YN; vc2s = 1'b1;
        end else begin
          en1 = yo; d1 = DIR_YN; vc1s = 1'b1; g1 = !bb[DIR_YN] || b1[DIR_XN];
          en2 = xo; d2 = DIR_XN; vc2s = 1'b1;
        end
      end
      CLASS_5: begin
        en1 = yo;        d1 = DIR_YP;
        en2 = xo && !yo; d2 = DIR_XP;
      end
      CLASS_6: begin
        if (!coin) begin
          en1 = xo; d1 = DIR_XN; g1 = !bb[DIR_XN] || b0[DIR_YP];
          en2 = yo; d2 = DIR_YP;
        end else begin
          en1 = yo; d1 = DIR_YP; g1 = !bb[DIR_YP] || b0[DIR_XN];
          en2 = xo; d2 = DIR_XN;
        end
      end
      CLASS_7: begin
        if (!coin) begin
          en1 = xo; d1 = DIR_XP; g1 = !bb[DIR_XP] || b0[DIR_YN];
          en2 = yo; d2 = DIR_YN;
        end else begin
          en1 = yo; d1 = DIR_YN; g1 = !bb[DIR_YN] || b0[DIR_XP];
          en2 = xo; d2 = DIR_XP;
        end
      end
      CLASS_8: begin
        if (!coin) begin
          en1 = xo; d1 = DIR_XN; vc1s = high_vc; g1 = !bb[DIR_XN] || b0[DIR_YN];
          en2 = yo; d2 = DIR_YN;
        end else begin
          en1 = yo; d1 = DIR_YN;
          g1 = !bb[DIR_YN] || (b0[DIR_XN] && b1[DIR_XN]);
          en2 = xo; d2 = DIR_XN; vc2s = high_vc;
        end
      end
      default: begin
        en1 = 1'b0;
        en2 = 1'b0;
      end
    endcase
  end

  always_comb begin
    hit1 = en1 && ok[d1] && !(vc1s ? b1[d1] : b0[d1]) && g1;
    hit2 = en2 && ok[d2] && !(vc2s ? b1[d2] : b0[d2]) && g2;
    res = '0;
    priority if (hit1) begin
      res.found = 1'b1;
      res.next_node = nid[d1];
      res.dir = d1;
      res.vc = vc1s;
    end else if (hit2) begin
      res.found = 1'b1;
      res.next_node = nid[d2];
      res.dir = d2;
      res.vc = vc2s;
    end else begin
      res = '0;
    end
  end

endmodule

// File: rtl/mesh_adaptive_route_vc_select.sv
// Top level of the mesh adaptive route and VC select block: input register,
// route logic, result register. Depends on marvs_pkg and marvs_route.
//
//   channel | ports                                   | direction
//   in      | in_valid/in_ready, node ids, class, busy | into block
//   out     | out_valid/out_ready, found, node, dir, vc | out of block
//
// A beat passes through the input register, then the route logic feeding
// the result register. One beat per cycle is sustained while out_ready is
// high. Reset clears both valid bits; payload registers are not reset.
// A stalled result holds the result register, and the input register keeps
// accepting until it also holds a waiting beat.
module mesh_adaptive_route_vc_select import marvs_pkg::*; #(
  parameter int MESH_RADIX = MESH_RADIX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NODE_W-1:0] in_cur_node,
  input  logic [NODE_W-1:0] in_dst_node,
  input  logic [NODE_W-1:0] in_prev_node,
  input  logic [3:0]        in_msg_class,
  input  logic              in_prev_vc,
  input  logic              in_coin,
  input  logic [3:0]        in_vc0_busy,
  input  logic [3:0]        in_vc1_busy,
  input  logic [3:0]        in_bw_busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [NODE_W-1:0] out_next_node,
  output logic [1:0]        out_dir,
  output logic              out_vc
);

  logic              s1_valid_r;
  logic [NODE_W-1:0] cur_r, dst_r, prv_r;
  logic [3:0]        cls_r, v0_r, v1_r, bw_r;
  logic              pvc_r, coin_r;
  logic              out_valid_r;
  route_res_t        res_r, res_nxt;
  logic              s2_en, s1_en;

  assign s2_en    = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_en;
  assign s1_en    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s2_en) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      cur_r  <= in_cur_node;
      dst_r  <= in_dst_node;
      prv_r  <= in_prev_node;
      cls_r  <= in_msg_class;
      pvc_r  <= in_prev_vc;
      coin_r <= in_coin;
      v0_r   <= in_vc0_busy;
      v1_r   <= in_vc1_busy;
      bw_r   <= in_bw_busy;
    end
    if (s2_en && s1_valid_r) res_r <= res_nxt;
  end

  marvs_route #(
    .MESH_RADIX(MESH_RADIX)
  ) u_route (
    .cur_node  (cur_r),
    .dst_node  (dst_r),
    .prev_node (prv_r),
    .msg_class (cls_r),
    .prev_vc   (pvc_r),
    .coin      (coin_r),
    .vc0_busy  (v0_r),
    .vc1_busy  (v1_r),
    .bw_busy   (bw_r),
    .res       (res_nxt)
  );

  assign out_valid     = out_valid_r;
  assign out_found     = res_r.found;
  assign out_next_node = res_r.next_node;
  assign out_dir       = res_r.dir;
  assign out_vc        = res_r.vc;

  a_nohop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_next_node == '0 && out_dir == DIR_XP && !out_vc)
    else $error("no-route result carries nonzero fields");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty input register");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_en |=> out_valid)
    else $error("beat lost between input and result register");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_en |=> s1_valid_r && $stable(cur_r) && $stable(cls_r))
    else $error("waiting input beat overwritten");

endmodule
